// ===== design/convex_support_point_search_core_macros.svh =====
// ----------------------------------------------------------------------------
// Convex support point search: assertion macros
// Shared concurrent assertion forms, clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef CONVEX_SUPPORT_POINT_SEARCH_CORE_MACROS_SVH
`define CONVEX_SUPPORT_POINT_SEARCH_CORE_MACROS_SVH

// Same-cycle implication: whenever ante holds, cons holds too.
`define CSPS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: whenever ante holds, cons holds in the next cycle.
`define CSPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/csps_pkg.sv =====
// ----------------------------------------------------------------------------
// Convex support point search package
// Widths, codes and controller-to-datapath command type.
// ----------------------------------------------------------------------------
package csps_pkg;

    localparam int DEF_MAX_VERTICES = 64;
    localparam int COORD_W          = 32;
    localparam int VERTEX_W         = 3 * COORD_W;
    localparam int PROD_W           = 2 * COORD_W;
    localparam int SUM_W            = PROD_W + 2;
    localparam int IDX_W            = 6;

    typedef enum logic
    {
        OP_ADD   = 1'b0,
        OP_QUERY = 1'b1
    } opcode_t;

    typedef enum logic [1:0]
    {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Commands from the controller to the datapath, valid for one cycle each.
    typedef struct packed
    {
        logic wr_en;      // write the input vertex at the address
        logic ld_dir;     // capture the query direction
        logic rd_en;      // read the vertex at the address into the dot pipeline
        logic ld_add;     // load an add result (index from the address)
        logic ld_empty;   // load an empty-list result
        logic ld_full;    // load a full-list result
        logic ld_query;   // load the winning vertex as the result
    } csps_cmd_t;

endpackage

// ===== design/csps_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module csps_ram
#(
    parameter int WIDTH = 96,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             re,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (re)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/csps_dp.sv =====
// ----------------------------------------------------------------------------
// Convex support point search datapath
// Vertex RAM, three-lane dot product pipeline, running maximum, result register.
// ----------------------------------------------------------------------------
module csps_dp
    import csps_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    localparam int AW          = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  csps_cmd_t                 cmd,
    input  logic [AW-1:0]             addr,
    input  logic signed [COORD_W-1:0] coord_x,
    input  logic signed [COORD_W-1:0] coord_y,
    input  logic signed [COORD_W-1:0] coord_z,
    output logic                      pipe_busy,
    output logic                      done,
    output logic signed [COORD_W-1:0] point_x,
    output logic signed [COORD_W-1:0] point_y,
    output logic signed [COORD_W-1:0] point_z,
    output logic [IDX_W-1:0]          point_index,
    output status_t                   status
);

    localparam int EW = (AW > IDX_W) ? AW : IDX_W;

    logic [VERTEX_W-1:0]       rd_vertex;
    logic signed [COORD_W-1:0] rd_x;
    logic signed [COORD_W-1:0] rd_y;
    logic signed [COORD_W-1:0] rd_z;

    logic signed [COORD_W-1:0] dir_x_reg;
    logic signed [COORD_W-1:0] dir_y_reg;
    logic signed [COORD_W-1:0] dir_z_reg;

    logic                      v1_reg;
    logic [AW-1:0]             idx1_reg;
    logic                      v2_reg;
    logic [AW-1:0]             idx2_reg;
    logic [VERTEX_W-1:0]       data2_reg;
    logic signed [PROD_W-1:0]  px_reg;
    logic signed [PROD_W-1:0]  py_reg;
    logic signed [PROD_W-1:0]  pz_reg;
    logic                      v3_reg;
    logic [AW-1:0]             idx3_reg;
    logic [VERTEX_W-1:0]       data3_reg;
    logic signed [SUM_W-1:0]   sum_reg;
    logic signed [SUM_W-1:0]   sum_next;

    logic signed [SUM_W-1:0]   best_sum_reg;
    logic [AW-1:0]             best_idx_reg;
    logic [VERTEX_W-1:0]       best_data_reg;
    logic                      take_best;

    logic                      done_reg;
    logic signed [COORD_W-1:0] res_x_reg;
    logic signed [COORD_W-1:0] res_y_reg;
    logic signed [COORD_W-1:0] res_z_reg;
    logic [IDX_W-1:0]          res_idx_reg;
    status_t                   res_status_reg;

    logic [EW-1:0]             addr_ext;
    logic [EW-1:0]             best_ext;

    csps_ram
    #(
        .WIDTH (VERTEX_W),
        .DEPTH (MAX_VERTICES)
    )
    u_vertex_ram
    (
        .clk     (clk),
        .we      (cmd.wr_en),
        .wr_addr (addr),
        .wr_data ({coord_z, coord_y, coord_x}),
        .re      (cmd.rd_en),
        .rd_addr (addr),
        .rd_data (rd_vertex)
    );

    assign rd_x = rd_vertex[COORD_W-1:0];
    assign rd_y = rd_vertex[2*COORD_W-1:COORD_W];
    assign rd_z = rd_vertex[3*COORD_W-1:2*COORD_W];

    assign sum_next = SUM_W'(px_reg) + SUM_W'(py_reg) + SUM_W'(pz_reg);

    // Vertex 0 always seeds the maximum; later ones need a strictly greater
    // dot product, so the lowest index wins a tie.
    assign take_best = v3_reg && ((idx3_reg == '0) || (sum_reg > best_sum_reg));

    assign addr_ext = EW'(addr);
    assign best_ext = EW'(best_idx_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= cmd.rd_en;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            done_reg <= cmd.ld_add | cmd.ld_empty | cmd.ld_full | cmd.ld_query;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ld_dir)
        begin
            dir_x_reg <= coord_x;
            dir_y_reg <= coord_y;
            dir_z_reg <= coord_z;
        end

        idx1_reg  <= addr;
        idx2_reg  <= idx1_reg;
        data2_reg <= rd_vertex;
        px_reg    <= dir_x_reg * rd_x;
        py_reg    <= dir_y_reg * rd_y;
        pz_reg    <= dir_z_reg * rd_z;
        idx3_reg  <= idx2_reg;
        data3_reg <= data2_reg;
        sum_reg   <= sum_next;

        if (take_best)
        begin
            best_sum_reg  <= sum_reg;
            best_idx_reg  <= idx3_reg;
            best_data_reg <= data3_reg;
        end

        if (cmd.ld_add)
        begin
            res_x_reg      <= '0;
            res_y_reg      <= '0;
            res_z_reg      <= '0;
            res_idx_reg    <= addr_ext[IDX_W-1:0];
            res_status_reg <= ST_OK;
        end
        else if (cmd.ld_empty || cmd.ld_full)
        begin
            res_x_reg      <= '0;
            res_y_reg      <= '0;
            res_z_reg      <= '0;
            res_idx_reg    <= '0;
            res_status_reg <= cmd.ld_full ? ST_FULL : ST_EMPTY;
        end
        else if (cmd.ld_query)
        begin
            res_x_reg      <= best_data_reg[COORD_W-1:0];
            res_y_reg      <= best_data_reg[2*COORD_W-1:COORD_W];
            res_z_reg      <= best_data_reg[3*COORD_W-1:2*COORD_W];
            res_idx_reg    <= best_ext[IDX_W-1:0];
            res_status_reg <= ST_OK;
        end
    end

    assign pipe_busy   = v1_reg | v2_reg | v3_reg;
    assign done        = done_reg;
    assign point_x     = res_x_reg;
    assign point_y     = res_y_reg;
    assign point_z     = res_z_reg;
    assign point_index = res_idx_reg;
    assign status      = res_status_reg;

endmodule

// ===== design/csps_ctrl.sv =====
// ----------------------------------------------------------------------------
// Convex support point search controller
// Keeps the vertex count and sequences the query scan over the vertex RAM.
// ----------------------------------------------------------------------------
`include "convex_support_point_search_core_macros.svh"

module csps_ctrl
    import csps_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    localparam int AW          = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1,
    localparam int CW          = $clog2(MAX_VERTICES + 1)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  opcode_t       opcode,
    input  logic          pipe_busy,
    output logic          busy,
    output csps_cmd_t     cmd,
    output logic [AW-1:0] addr
);

    typedef enum logic [2:0]
    {
        S_IDLE  = 3'b001,
        S_SCAN  = 3'b010,
        S_DRAIN = 3'b100
    } state_t;

    state_t        state_reg;
    state_t        state_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [AW-1:0] scan_reg;
    logic [AW-1:0] scan_next;
    logic          full;

    assign full = (count_reg == CW'(MAX_VERTICES));
    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        scan_next  = scan_reg;
        cmd        = '0;
        addr       = count_reg[AW-1:0];
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (opcode == OP_ADD)
                    begin
                        if (full)
                        begin
                            cmd.ld_full = 1'b1;
                        end
                        else
                        begin
                            cmd.wr_en  = 1'b1;
                            cmd.ld_add = 1'b1;
                            count_next = count_reg + CW'(1);
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        cmd.ld_empty = 1'b1;
                    end
                    else
                    begin
                        cmd.ld_dir = 1'b1;
                        scan_next  = '0;
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                cmd.rd_en = 1'b1;
                addr      = scan_reg;
                if (CW'(scan_reg) == count_reg - CW'(1))
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    scan_next = scan_reg + AW'(1);
                end
            end
            S_DRAIN:
            begin
                if (!pipe_busy)
                begin
                    cmd.ld_query = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            scan_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            scan_reg  <= scan_next;
        end
    end

    `CSPS_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CW'(MAX_VERTICES), "vertex count past capacity")
    `CSPS_ASSERT_NOW(a_scan_in_list, state_reg == S_SCAN, CW'(scan_reg) < count_reg, "scan beyond the stored vertices")
    `CSPS_ASSERT_NEXT(a_add_counts, start && !busy && opcode == OP_ADD && !full, count_reg == $past(count_reg) + CW'(1), "accepted add did not grow the list")
    `CSPS_ASSERT_NEXT(a_query_scans, start && !busy && opcode == OP_QUERY && count_reg != '0, state_reg == S_SCAN && scan_reg == '0, "query did not start its scan at vertex 0")

endmodule

// ===== design/convex_support_point_search_core.sv =====
// ----------------------------------------------------------------------------
// Convex support point search core
// Vertex list with a support-point query: returns the stored vertex that lies
// farthest along a given direction, as used by a GJK collision test.
// ----------------------------------------------------------------------------
// Every accepted beat produces exactly one result beat, shown for one cycle
// with done high, and the receiver cannot hold it off, so sample the result
// outputs whenever done is high. A beat is accepted at a clock edge where start
// is high and busy is low. An add beat (opcode 0) appends the x, y, z vertex
// and is finished in the accept cycle: its result follows in the next cycle and
// busy stays low, so adds may be issued every cycle. A query beat (opcode 1)
// with an empty list is equally quick and reports status 1. A query on a list
// of N vertices keeps busy high while it reads the N vertices and drains the
// pipeline, and shows its result in the first cycle with busy low again; the
// single read port of the vertex RAM, which delivers one vertex per cycle,
// paces the scan, and the multiply, sum and compare stages fill and drain
// around it. An add to a full list drops the vertex and reports status 2.
//
// Coordinates are signed Q16.16. The three 32 by 32 products of the dot
// product are formed in parallel in one stage, summed exactly at 66 bits in
// the next, and compared against the running maximum in the third. A later
// vertex replaces the current best only on a strictly greater dot product,
// so on a tie the lowest index wins; a zero direction returns vertex 0.
// The reported index is the vertex position modulo 64. The vertex RAM needs
// no clearing after reset: only entries below the vertex count are read.
// ----------------------------------------------------------------------------
module convex_support_point_search_core
    import csps_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      opcode,
    input  logic signed [COORD_W-1:0] coord_x,
    input  logic signed [COORD_W-1:0] coord_y,
    input  logic signed [COORD_W-1:0] coord_z,
    output logic                      done,
    output logic signed [COORD_W-1:0] point_x,
    output logic signed [COORD_W-1:0] point_y,
    output logic signed [COORD_W-1:0] point_z,
    output logic [IDX_W-1:0]          point_index,
    output logic [1:0]                status
);

    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

    // Command bundle and shared RAM address from the controller.
    csps_cmd_t     cmd;
    logic [AW-1:0] addr;
    logic          pipe_busy;
    opcode_t       op;
    status_t       status_code;

    assign op = opcode_t'(opcode);

    csps_ctrl
    #(
        .MAX_VERTICES (MAX_VERTICES)
    )
    u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .opcode    (op),
        .pipe_busy (pipe_busy),
        .busy      (busy),
        .cmd       (cmd),
        .addr      (addr)
    );

    csps_dp
    #(
        .MAX_VERTICES (MAX_VERTICES)
    )
    u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .addr        (addr),
        .coord_x     (coord_x),
        .coord_y     (coord_y),
        .coord_z     (coord_z),
        .pipe_busy   (pipe_busy),
        .done        (done),
        .point_x     (point_x),
        .point_y     (point_y),
        .point_z     (point_z),
        .point_index (point_index),
        .status      (status_code)
    );

    assign status = status_code;

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Convex support point search core: block-level testbench
// Builds a vertex list through add beats and checks that query beats return
// the farthest vertex along a direction, with its index and status. Results
// are predicted by an independent exact dot-product search and compared field
// by field in arrival order.
// ----------------------------------------------------------------------------
module tb_top;
    import csps_pkg::*;

    localparam int          LIST_DEPTH  = DEF_MAX_VERTICES;
    localparam int          RANDOM_BEATS = 1270;
    localparam int          TAIL_BEATS  = 200;
    localparam int          TAIL_CYCLES = 100;
    localparam int          MAX_REPORTS = 10;
    localparam realtime     TIMEOUT_NS  = 3_000_000.0;

    localparam logic [COORD_W-1:0] POS_MAX = 32'h7FFF_FFFF;
    localparam logic [COORD_W-1:0] NEG_MAX = 32'h8000_0000;
    localparam logic [COORD_W-1:0] MINUS_1 = 32'hFFFF_FFFF;
    localparam logic [COORD_W-1:0] Q_ONE   = 32'h0001_0000;

    // One expected result beat.
    typedef struct packed
    {
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
        logic [COORD_W-1:0] pz;
        logic [IDX_W-1:0]   idx;
        status_t            st;
    } support_result_t;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic                      opcode;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
    logic                      done;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
    logic [IDX_W-1:0]          point_index;
    logic [1:0]                status;

    // Shadow copy of the vertex list, updated when a beat is accepted.
    logic [COORD_W-1:0] vertex_x [LIST_DEPTH];
    logic [COORD_W-1:0] vertex_y [LIST_DEPTH];
    logic [COORD_W-1:0] vertex_z [LIST_DEPTH];
    int                 vertex_total = 0;

    // Results still owed by the block, oldest first.
    support_result_t    pending_supports[$];
    int                 mismatch_count = 0;

    always #2 clk = ~clk;

    convex_support_point_search_core #(
        .MAX_VERTICES (LIST_DEPTH)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .opcode      (opcode),
        .coord_x     (coord_x),
        .coord_y     (coord_y),
        .coord_z     (coord_z),
        .done        (done),
        .point_x     (point_x),
        .point_y     (point_y),
        .point_z     (point_z),
        .point_index (point_index),
        .status      (status)
    );

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Applies one accepted beat to the shadow list and returns the result the
    // block owes for it. The dot product is kept exact at SUM_W bits, so even
    // three products of the most negative coordinate cannot wrap. Only a
    // strictly greater dot product moves the choice, so ties keep the lowest
    // index.
    function automatic support_result_t predict_support(opcode_t op,
        logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy, logic [COORD_W-1:0] cz);
        support_result_t         r;
        logic signed [SUM_W-1:0] best_dot;
        logic signed [SUM_W-1:0] dot;
        longint                  prod_x;
        longint                  prod_y;
        longint                  prod_z;
        int                      best;
        r = '0;
        r.st = ST_OK;
        if (op == OP_ADD)
        begin
            // A full list drops the vertex and reports zero coordinates and index.
            if (vertex_total >= LIST_DEPTH)
            begin
                r.st = ST_FULL;
            end
            else
            begin
                vertex_x[vertex_total] = cx;
                vertex_y[vertex_total] = cy;
                vertex_z[vertex_total] = cz;
                r.idx = IDX_W'(vertex_total);
                vertex_total++;
            end
            return r;
        end
        if (vertex_total == 0)
        begin
            r.st = ST_EMPTY;
            return r;
        end
        best = 0;
        best_dot = '0;
        for (int i = 0; i < vertex_total; i++)
        begin
            prod_x = longint'($signed(cx)) * longint'($signed(vertex_x[i]));
            prod_y = longint'($signed(cy)) * longint'($signed(vertex_y[i]));
            prod_z = longint'($signed(cz)) * longint'($signed(vertex_z[i]));
            dot = prod_x;
            dot = dot + prod_y;
            dot = dot + prod_z;
            if (i == 0 || dot > best_dot)
            begin
                best_dot = dot;
                best = i;
            end
        end
        r.px  = vertex_x[best];
        r.py  = vertex_y[best];
        r.pz  = vertex_z[best];
        r.idx = IDX_W'(best);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------

    task automatic check_field(string label, logic [COORD_W-1:0] want_v,
        logic [COORD_W-1:0] got_v);
        if (got_v !== want_v)
        begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %h, got %h",
                    $realtime, label, want_v, got_v);
        end
    endtask

    // A result beat is shown for exactly one cycle and cannot be held off, so
    // every cycle with done high is consumed against the oldest expectation.
    always @(posedge clk)
    begin : result_monitor
        support_result_t want;
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (pending_supports.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: result beat with nothing pending, index %0d status %0d",
                        $realtime, point_index, status);
            end
            else
            begin
                want = pending_supports.pop_front();
                check_field("point_x", want.px, point_x);
                check_field("point_y", want.py, point_y);
                check_field("point_z", want.pz, point_z);
                check_field("point_index", COORD_W'(want.idx), COORD_W'(point_index));
                check_field("status", COORD_W'(want.st), COORD_W'(status));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Drives one beat at the falling edge and holds it until a rising edge
    // sees busy low. Start is left high so a following beat can go out
    // back to back; gaps and drains lower it.
    task automatic send_beat(opcode_t op, logic [COORD_W-1:0] cx,
        logic [COORD_W-1:0] cy, logic [COORD_W-1:0] cz);
        @(negedge clk);
        start   <= 1'b1;
        opcode  <= op;
        coord_x <= cx;
        coord_y <= cy;
        coord_z <= cz;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        pending_supports.insert(pending_supports.size(),
            predict_support(op, cx, cy, cz));
    endtask

    // With the given chance, keeps start low for a burst of random length.
    task automatic maybe_gap(int pct);
        int n;
        if ($urandom_range(0, 99) < pct)
        begin
            n = $urandom_range(1, 6);
            repeat (n)
            begin
                @(negedge clk);
                start <= 1'b0;
            end
        end
    endtask

    // Stops sending and waits until every owed result has arrived.
    task automatic wait_for_drain();
        @(negedge clk);
        start <= 1'b0;
        while (pending_supports.size() != 0)
            @(negedge clk);
    endtask

    // Mix of full-range values, whole units in a narrow range (so dot
    // products tie often), raw small values and the extremes.
    function automatic logic [COORD_W-1:0] random_coord();
        int step;
        step = int'($urandom_range(0, 8)) - 4;
        case ($urandom_range(0, 4))
            0, 1: return $urandom();
            2:    return COORD_W'(step * 65536);
            3:    return COORD_W'(step);
            default:
            begin
                case ($urandom_range(0, 3))
                    0:       return POS_MAX;
                    1:       return NEG_MAX;
                    2:       return MINUS_1;
                    default: return '0;
                endcase
            end
        endcase
    endfunction

    // Appends a random vertex; now and then a copy of a stored one, which
    // forces exact ties between two indexes.
    task automatic send_vertex();
        int pick;
        if (vertex_total > 0 && $urandom_range(0, 7) == 0)
        begin
            pick = $urandom_range(0, vertex_total - 1);
            send_beat(OP_ADD, vertex_x[pick], vertex_y[pick], vertex_z[pick]);
        end
        else
        begin
            send_beat(OP_ADD, random_coord(), random_coord(), random_coord());
        end
    endtask

    task automatic send_query();
        if ($urandom_range(0, 15) == 0)
            send_beat(OP_QUERY, '0, '0, '0);
        else
            send_beat(OP_QUERY, random_coord(), random_coord(), random_coord());
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Queries before any vertex exists must report an empty list.
    task automatic test_empty_list();
        send_beat(OP_QUERY, '0, '0, '0);
        send_beat(OP_QUERY, POS_MAX, NEG_MAX, MINUS_1);
    endtask

    // A small hand-built list with the coordinate extremes, a duplicate of
    // vertex 0 for the tie rule, and directions that pick each distinct vertex.
    task automatic test_directed_vertices();
        send_beat(OP_ADD, POS_MAX, NEG_MAX, '0);
        send_beat(OP_ADD, NEG_MAX, POS_MAX, MINUS_1);
        send_beat(OP_ADD, '0, '0, POS_MAX);
        send_beat(OP_ADD, POS_MAX, NEG_MAX, '0);
        send_beat(OP_ADD, NEG_MAX, NEG_MAX, NEG_MAX);
        // A zero direction ties every vertex, so vertex 0 comes back.
        send_beat(OP_QUERY, '0, '0, '0);
        send_beat(OP_QUERY, Q_ONE, '0, '0);
        // Three products of the most negative values need the full sum width.
        send_beat(OP_QUERY, NEG_MAX, NEG_MAX, NEG_MAX);
        send_beat(OP_QUERY, POS_MAX, POS_MAX, POS_MAX);
        send_beat(OP_QUERY, '0, '0, Q_ONE);
        send_beat(OP_QUERY, MINUS_1, '0, '0);
        send_beat(OP_QUERY, '0, POS_MAX, NEG_MAX);
    endtask

    // Fills the list to capacity with queries in between, so searches run
    // over the list as it grows.
    task automatic test_growing_list();
        while (vertex_total < LIST_DEPTH)
        begin
            if ($urandom_range(0, 9) < 4)
                send_vertex();
            else
                send_query();
            maybe_gap(30);
        end
    endtask

    // Adds to a full list are dropped; the list must still answer as before.
    task automatic test_full_list();
        send_beat(OP_ADD, POS_MAX, POS_MAX, POS_MAX);
        send_beat(OP_ADD, NEG_MAX, NEG_MAX, NEG_MAX);
        send_beat(OP_ADD, '0, '0, '0);
        send_beat(OP_QUERY, '0, '0, '0);
    endtask

    // Mostly queries over the full list, with dropped adds mixed in. Gaps
    // are switched on and off in stretches of 50 beats.
    task automatic test_random_mix();
        int gap_pct;
        gap_pct = 0;
        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            if (n % 50 == 0)
                gap_pct = ($urandom_range(0, 2) == 0) ? 0 : 35;
            if ($urandom_range(0, 99) < 15)
                send_vertex();
            else
                send_query();
            maybe_gap(gap_pct);
        end
    endtask

    // Closing stretch with start held high throughout.
    task automatic test_back_to_back();
        for (int n = 0; n < TAIL_BEATS; n++)
        begin
            if ($urandom_range(0, 99) < 20)
                send_vertex();
            else
                send_query();
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------

    initial
    begin
        rst_n   = 1'b0;
        start   = 1'b0;
        opcode  = OP_ADD;
        coord_x = '0;
        coord_y = '0;
        coord_z = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_list();
        test_directed_vertices();
        // Let every directed result land before random traffic starts.
        wait_for_drain();
        test_growing_list();
        test_full_list();
        wait_for_drain();
        test_random_mix();
        test_back_to_back();

        // Wait for the last results, then a little more to catch any extra
        // result beat the block might still show.
        wait_for_drain();
        repeat (TAIL_CYCLES) @(negedge clk);

        if (mismatch_count == 0)
            $display("convex_support_point_search_core verification clean");
        else
            $display("convex_support_point_search_core verification failed");
        $finish;
    end

    // Watchdog against a hung handshake or a missing result.
    initial
    begin
        #(TIMEOUT_NS);
        $display("convex_support_point_search_core verification failed");
        $finish;
    end

endmodule
